### rtl/bost_pkg.sv
// Shared types, codes and constants for the bulk-only transport host sequencer.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none

package bost_pkg;

   // default packet and sector sizes in bytes
   localparam int PACKET_BYTES_DEF = 64;
   localparam int SECTOR_BYTES_DEF = 512;

   // request function codes
   localparam logic FUNC_CMD  = 1'b0;
   localparam logic FUNC_XFER = 1'b1;

   // scsi command codes
   localparam logic [1:0] CMD_SENSE    = 2'd0;
   localparam logic [1:0] CMD_CAPACITY = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;
   localparam logic [1:0] CMD_WRITE    = 2'd3;

   // usb transfer status codes
   localparam logic [1:0] XST_OK      = 2'd0;
   localparam logic [1:0] XST_USB_ERR = 2'd1;
   localparam logic [1:0] XST_STS_ERR = 2'd2;
   localparam logic [1:0] XST_OTHER   = 2'd3;

   // transfer kinds on the result channel
   localparam logic [2:0] XFER_NONE     = 3'd0;
   localparam logic [2:0] XFER_CBW_OUT  = 3'd1;
   localparam logic [2:0] XFER_DATA_IN  = 3'd2;
   localparam logic [2:0] XFER_DATA_OUT = 3'd3;
   localparam logic [2:0] XFER_CSW_IN   = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_USB     = 3'd1;
   localparam logic [2:0] ERR_USB_STS = 3'd2;
   localparam logic [2:0] ERR_CSW_LEN = 3'd3;
   localparam logic [2:0] ERR_CSW_SIG = 3'd4;
   localparam logic [2:0] ERR_CSW_STS = 3'd5;

   // csw checks
   localparam logic [31:0] CSW_SIG = 32'h5553_4253;
   localparam logic [6:0]  CSW_LEN = 7'd13;

   // cdb bytes 2..5 for request sense (allocation length byte)
   localparam logic [31:0] SENSE_LBA = 32'h0000_1200;

   // fixed cbw lengths for the short commands
   localparam logic [9:0] SENSE_LEN    = 10'd16;
   localparam logic [9:0] CAPACITY_LEN = 10'd8;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // input item
   typedef struct packed {
      logic        func;
      logic [1:0]  command;
      logic [1:0]  xfer_status;
      logic [6:0]  byte_count;
      logic [31:0] csw_signature;
      logic [7:0]  csw_status;
      logic [31:0] capacity_word;
   } req_type;

   // result item
   typedef struct packed {
      logic [2:0]  xfer_kind;
      logic [8:0]  buf_offset;
      logic [7:0]  cbw_opcode;
      logic [9:0]  cbw_length;
      logic        cbw_dir_in;
      logic [31:0] cbw_lba;
      logic        cmd_done;
      logic [2:0]  error_code;
      logic [31:0] last_sector;
      logic        busy_res;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic        is_cmd;
      logic [1:0]  command;
      logic [2:0]  xfer_err;
      logic [2:0]  csw_err;
      logic [31:0] capacity_word;
   } item_type;

   // scsi opcode for each command
   function automatic logic [7:0] cmd_opcode(input logic [1:0] cmd);
      logic [7:0] op;
      unique case (cmd)
         CMD_SENSE:    op = 8'h03;
         CMD_CAPACITY: op = 8'h25;
         CMD_READ:     op = 8'h28;
         CMD_WRITE:    op = 8'h2a;
         default:      op = 8'h00;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

### rtl/bost_front.sv
// Front end: takes request items and classifies them into compact records.
// Depends on bost_pkg; feeds bost_queue.
`default_nettype none

module bost_front (
   input  wire               req_valid,
   input  wire               queue_full,
   input  bost_pkg::req_type req_data,
   output logic              req_stall,
   output logic              push,
   output bost_pkg::item_type item
);

   // handshake: hold off while the queue is full
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // usb status and csw checks folded into error codes
   always_comb begin
      item.is_cmd        = (req_data.func == bost_pkg::FUNC_CMD);
      item.command       = req_data.command;
      item.capacity_word = req_data.capacity_word;

      unique case (req_data.xfer_status)
         bost_pkg::XST_OK:      item.xfer_err = bost_pkg::ERR_NONE;
         bost_pkg::XST_USB_ERR: item.xfer_err = bost_pkg::ERR_USB;
         bost_pkg::XST_STS_ERR: item.xfer_err = bost_pkg::ERR_USB_STS;
         bost_pkg::XST_OTHER:   item.xfer_err = bost_pkg::ERR_USB;
         default:               item.xfer_err = bost_pkg::ERR_USB;
      endcase

      priority if (req_data.byte_count != bost_pkg::CSW_LEN) begin
         item.csw_err = bost_pkg::ERR_CSW_LEN;
      end else if (req_data.csw_signature != bost_pkg::CSW_SIG) begin
         item.csw_err = bost_pkg::ERR_CSW_SIG;
      end else if (req_data.csw_status != 8'd0) begin
         item.csw_err = bost_pkg::ERR_CSW_STS;
      end else begin
         item.csw_err = bost_pkg::ERR_NONE;
      end
   end

endmodule

`default_nettype wire

### rtl/bost_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Depends on bost_pkg for the item type and depth.
`default_nettype none

module bost_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  bost_pkg::item_type push_item,
   input  wire                pop,
   output logic               full,
   output logic               not_empty,
   output bost_pkg::item_type head_item
);

   localparam int PtrW = (bost_pkg::QUEUE_DEPTH > 1) ? $clog2(bost_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(bost_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(bost_pkg::QUEUE_DEPTH - 1);

   bost_pkg::item_type slot_ff [bost_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntW'(bost_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### rtl/bost_back.sv
// Back end: transport phase sequencer and result register with its handshake.
// Depends on bost_pkg; consumes items from bost_queue.
`default_nettype none

module bost_back #(
   parameter int PACKET_BYTES = bost_pkg::PACKET_BYTES_DEF,
   parameter int SECTOR_BYTES = bost_pkg::SECTOR_BYTES_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                item_valid,
   input  bost_pkg::item_type item,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output bost_pkg::rsp_type  rsp_data
);

   localparam int MaxLen = (SECTOR_BYTES > PACKET_BYTES) ? SECTOR_BYTES : PACKET_BYTES;
   localparam int CntW   = $clog2(MaxLen + 1);
   localparam logic [CntW-1:0] PacketCnt = CntW'(PACKET_BYTES);
   localparam logic [CntW-1:0] SectorCnt = CntW'(SECTOR_BYTES);
   localparam logic [9:0]      SectorLen = 10'(SECTOR_BYTES);

   // phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CBW  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_CSW  = 2'd3;

   logic [1:0]      phase_ff, phase_in;
   logic [1:0]      active_ff, active_in;
   logic [CntW-1:0] left_ff, left_in;
   logic [CntW-1:0] offset_ff, offset_in;
   logic [31:0]     sector_ff, sector_in;
   logic [31:0]     pending_ff, pending_in;
   logic            rsp_valid_ff, rsp_valid_in;
   bost_pkg::rsp_type rsp_ff, rsp_in;
   bost_pkg::rsp_type res;
   logic [2:0]      data_kind;
   logic [31:0]     offset_wide;
   logic            take;

   // take the head item whenever the result slot is free or draining
   assign take      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop       = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign data_kind = (active_ff == bost_pkg::CMD_WRITE) ?
                      bost_pkg::XFER_DATA_OUT : bost_pkg::XFER_DATA_IN;

   // phase sequencer
   always_comb begin
      phase_in    = phase_ff;
      active_in   = active_ff;
      left_in     = left_ff;
      offset_in   = offset_ff;
      sector_in   = sector_ff;
      pending_in  = pending_ff;
      res         = '0;
      offset_wide = '0;

      if (item.is_cmd) begin
         if (phase_ff == PH_IDLE) begin
            active_in      = item.command;
            left_in        = (item.command[1]) ? SectorCnt : PacketCnt;
            offset_in      = '0;
            phase_in       = PH_CBW;
            res.xfer_kind  = bost_pkg::XFER_CBW_OUT;
            res.cbw_opcode = bost_pkg::cmd_opcode(item.command);
            unique case (item.command)
               bost_pkg::CMD_SENSE: begin
                  res.cbw_length = bost_pkg::SENSE_LEN;
                  res.cbw_lba    = bost_pkg::SENSE_LBA;
               end
               bost_pkg::CMD_CAPACITY: begin
                  res.cbw_length = bost_pkg::CAPACITY_LEN;
                  res.cbw_lba    = '0;
               end
               default: begin
                  res.cbw_length = SectorLen;
                  res.cbw_lba    = sector_ff;
               end
            endcase
            res.cbw_dir_in = (item.command != bost_pkg::CMD_WRITE);
         end
      end else if (phase_ff != PH_IDLE) begin
         priority if (item.xfer_err != bost_pkg::ERR_NONE) begin
            phase_in       = PH_IDLE;
            res.cmd_done   = 1'b1;
            res.error_code = item.xfer_err;
         end else if (phase_ff == PH_CBW) begin
            phase_in       = PH_DATA;
            res.xfer_kind  = data_kind;
            offset_wide    = 32'(offset_ff);
            res.buf_offset = offset_wide[8:0];
         end else if (phase_ff == PH_DATA) begin
            // capacity word comes with the first packet of read capacity
            if (active_ff == bost_pkg::CMD_CAPACITY && offset_ff == '0) begin
               pending_in = item.capacity_word;
            end
            if (left_ff > PacketCnt) begin
               left_in        = left_ff - PacketCnt;
               offset_in      = offset_ff + PacketCnt;
               res.xfer_kind  = data_kind;
               offset_wide    = 32'(offset_in);
               res.buf_offset = offset_wide[8:0];
            end else begin
               left_in       = '0;
               phase_in      = PH_CSW;
               res.xfer_kind = bost_pkg::XFER_CSW_IN;
            end
         end else begin
            phase_in       = PH_IDLE;
            res.cmd_done   = 1'b1;
            res.error_code = item.csw_err;
            if (item.csw_err == bost_pkg::ERR_NONE && active_ff == bost_pkg::CMD_CAPACITY) begin
               sector_in = pending_ff;
            end
         end
      end

      res.last_sector = sector_in;
      res.busy_res    = (phase_in != PH_IDLE);
   end

   // result slot handshake
   always_comb begin
      rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
      rsp_in       = take ? res : rsp_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         active_ff    <= '0;
         left_ff      <= '0;
         offset_ff    <= '0;
         sector_ff    <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            active_ff  <= active_in;
            left_ff    <= left_in;
            offset_ff  <= offset_in;
            sector_ff  <= sector_in;
            pending_ff <= pending_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

### rtl/bulk_only_scsi_host_sequencer.sv
// Host sequencer for usb bulk-only mass-storage transport.
// Channel req_ carries command requests and usb transfer completions; rsp_ returns
// one item per request item: the next transfer to start, or the command outcome.
// Both channels use valid/stall: an item moves on a clock edge with valid high and
// stall low. The front end classifies each request item (usb status, csw size,
// signature and status checks) and writes it into a two-entry queue; the back end
// runs the cbw / data / csw phase machine and holds its result in an output
// register. An accepted request item passes through a queue slot and the result
// register; one item per cycle is sustained while rsp_stall stays low.
// When the receiver stalls, the result register holds its item, the back end stops
// taking from the queue and req_stall rises once the queue is full (two items).
// Synchronous reset returns the sequencer to idle with the stored last sector
// cleared, empties the queue and drops rsp_valid.
// Depends on bost_pkg, bost_front, bost_queue and bost_back.
`default_nettype none

module bulk_only_scsi_host_sequencer #(
   parameter int PACKET_BYTES = bost_pkg::PACKET_BYTES_DEF,
   parameter int SECTOR_BYTES = bost_pkg::SECTOR_BYTES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  bost_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output bost_pkg::rsp_type rsp_data
);

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_not_empty;
   bost_pkg::item_type front_item;
   bost_pkg::item_type head_item;

   // classify incoming items
   bost_front u_front (
      .req_valid  (req_valid),
      .queue_full (queue_full),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .push       (push),
      .item       (front_item)
   );

   // decoupling queue
   bost_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   // phase sequencer and result register
   bost_back #(
      .PACKET_BYTES (PACKET_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### dv/bulk_only_scsi_host_sequencer_checker.sv
// Checker for the bulk-only transport host sequencer: watches both channels, predicts
// each result item from its own copy of the phase machine and compares field by field.
// Depends on bost_pkg for the item types and the transfer, command and error codes.
module bulk_only_scsi_host_sequencer_checker
   import bost_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_stall,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      awaited_count
);

   // scsi opcodes of the four command templates
   localparam logic [7:0] OPC_REQUEST_SENSE = 8'h03;
   localparam logic [7:0] OPC_READ_CAPACITY = 8'h25;
   localparam logic [7:0] OPC_READ10        = 8'h28;
   localparam logic [7:0] OPC_WRITE10       = 8'h2a;

   // only the first mismatches are printed, all are counted
   localparam int PRINT_LIMIT = 40;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_CBW, SEQ_DATA, SEQ_CSW} seq_phase_type;

   seq_phase_type seq_phase;
   logic [1:0]    cur_cmd;
   int            remaining_bytes;
   int            packet_offset;
   logic [31:0]   stored_sector;
   logic [31:0]   captured_capacity;

   rsp_type       awaited_transfers[$];
   int            errors;
   int            results_seen;

   // one line per mismatch up to the print limit, all counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < PRINT_LIMIT)
         $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                  results_seen, what, got, want);
      errors++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // the command ends here, well or badly
   task automatic end_command(inout rsp_type o, input logic [2:0] err);
      o.cmd_done   = 1'b1;
      o.error_code = err;
      seq_phase    = SEQ_IDLE;
   endtask

   // next transfer or command outcome for one accepted item
   task automatic predict_transfer(input req_type r, output rsp_type o);
      o = '0;
      if (r.func == FUNC_CMD) begin
         if (seq_phase == SEQ_IDLE) begin
            cur_cmd         = r.command;
            remaining_bytes = (r.command == CMD_READ || r.command == CMD_WRITE) ?
                              SECTOR_BYTES : PACKET_BYTES;
            packet_offset   = 0;
            seq_phase       = SEQ_CBW;
            o.xfer_kind     = XFER_CBW_OUT;
            case (r.command)
               CMD_SENSE: begin
                  o.cbw_opcode = OPC_REQUEST_SENSE;
                  o.cbw_length = SENSE_LEN;
                  o.cbw_dir_in = 1'b1;
                  o.cbw_lba    = SENSE_LBA;
               end
               CMD_CAPACITY: begin
                  o.cbw_opcode = OPC_READ_CAPACITY;
                  o.cbw_length = CAPACITY_LEN;
                  o.cbw_dir_in = 1'b1;
               end
               CMD_READ: begin
                  o.cbw_opcode = OPC_READ10;
                  o.cbw_length = 10'(SECTOR_BYTES);
                  o.cbw_dir_in = 1'b1;
                  o.cbw_lba    = stored_sector;
               end
               default: begin
                  o.cbw_opcode = OPC_WRITE10;
                  o.cbw_length = 10'(SECTOR_BYTES);
                  o.cbw_lba    = stored_sector;
               end
            endcase
         end
      end else if (seq_phase != SEQ_IDLE) begin
         if (r.xfer_status == XST_USB_ERR || r.xfer_status == XST_OTHER) begin
            end_command(o, ERR_USB);
         end else if (r.xfer_status == XST_STS_ERR) begin
            end_command(o, ERR_USB_STS);
         end else begin
            case (seq_phase)
               // cbw sent, first data packet next
               SEQ_CBW: begin
                  seq_phase    = SEQ_DATA;
                  o.xfer_kind  = (cur_cmd == CMD_WRITE) ? XFER_DATA_OUT : XFER_DATA_IN;
                  o.buf_offset = 9'(packet_offset);
               end
               // data packet done, another one or the csw
               SEQ_DATA: begin
                  if (cur_cmd == CMD_CAPACITY && packet_offset == 0)
                     captured_capacity = r.capacity_word;
                  if (remaining_bytes > PACKET_BYTES) begin
                     remaining_bytes -= PACKET_BYTES;
                     packet_offset   += PACKET_BYTES;
                     o.xfer_kind  = (cur_cmd == CMD_WRITE) ? XFER_DATA_OUT : XFER_DATA_IN;
                     o.buf_offset = 9'(packet_offset);
                  end else begin
                     remaining_bytes = 0;
                     seq_phase       = SEQ_CSW;
                     o.xfer_kind     = XFER_CSW_IN;
                  end
               end
               // csw received: size, signature, status
               default: begin
                  if (r.byte_count != CSW_LEN) begin
                     end_command(o, ERR_CSW_LEN);
                  end else if (r.csw_signature != CSW_SIG) begin
                     end_command(o, ERR_CSW_SIG);
                  end else if (r.csw_status != 8'h00) begin
                     end_command(o, ERR_CSW_STS);
                  end else begin
                     if (cur_cmd == CMD_CAPACITY)
                        stored_sector = captured_capacity;
                     end_command(o, ERR_NONE);
                  end
               end
            endcase
         end
      end
      o.last_sector = stored_sector;
      o.busy_res    = (seq_phase != SEQ_IDLE);
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         seq_phase         = SEQ_IDLE;
         cur_cmd           = CMD_SENSE;
         remaining_bytes   = 0;
         packet_offset     = 0;
         stored_sector     = '0;
         captured_capacity = '0;
         errors            = 0;
         results_seen      = 0;
         awaited_transfers.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_transfer(req_data, predicted);
            awaited_transfers.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_transfers.size() == 0) begin
               report_mismatch("item with nothing awaited, kind", rsp_data.xfer_kind,
                               XFER_NONE);
            end else begin
               oldest = awaited_transfers.pop_front();
               compare_field("xfer_kind", rsp_data.xfer_kind, oldest.xfer_kind);
               compare_field("buf_offset", rsp_data.buf_offset, oldest.buf_offset);
               compare_field("cbw_opcode", rsp_data.cbw_opcode, oldest.cbw_opcode);
               compare_field("cbw_length", rsp_data.cbw_length, oldest.cbw_length);
               compare_field("cbw_dir_in", rsp_data.cbw_dir_in, oldest.cbw_dir_in);
               compare_field("cbw_lba", rsp_data.cbw_lba, oldest.cbw_lba);
               compare_field("cmd_done", rsp_data.cmd_done, oldest.cmd_done);
               compare_field("error_code", rsp_data.error_code, oldest.error_code);
               compare_field("last_sector", rsp_data.last_sector, oldest.last_sector);
               compare_field("busy_res", rsp_data.busy_res, oldest.busy_res);
            end
            results_seen++;
         end
      end
      awaited_count  <= awaited_transfers.size();
      mismatch_count <= errors;
   end

endmodule

### dv/bulk_only_scsi_host_sequencer_tb.sv
// Testbench top for the bulk-only transport host sequencer: drives command requests
// and transfer completions with random idling, and gives the verdict.
// Depends on bost_pkg, the sequencer RTL and bulk_only_scsi_host_sequencer_checker.
module bulk_only_scsi_host_sequencer_tb;
   import bost_pkg::*;

   localparam int PACKET_BYTES = PACKET_BYTES_DEF;
   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
   localparam int ITEM_TARGET  = 2000;
   localparam int QUIET_ITEMS  = 200;
   localparam int CYCLE_LIMIT  = 400000;

   // how the status phase of a command is to end
   typedef enum {CSW_GOOD, CSW_BAD_SIZE, CSW_BAD_SIG, CSW_BAD_STATUS} csw_fault_type;

   localparam logic [1:0] FAULT_STATUS [3] = '{XST_USB_ERR, XST_STS_ERR, XST_OTHER};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int      mismatch_count;
   int      awaited_count;
   int      cycle_count;
   int      gap_pct;
   int      stall_pct;
   int      stall_left;
   bit      quiet_tail;
   int      sequence_items;
   int      next_mode_change;

   bulk_only_scsi_host_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   bulk_only_scsi_host_sequencer_checker #(
      .PACKET_BYTES (PACKET_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls in bursts of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0)
            rsp_stall <= 1'b0;
      end else if (!quiet_tail && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(6, 1);
      end
   end

   // half the time an extreme, otherwise any word
   function automatic logic [31:0] random_word();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int idle_choice();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 15;
         default: return 50;
      endcase
   endfunction

   function automatic req_type cmd_item(input logic [1:0] cmd);
      req_type item;
      item.func          = FUNC_CMD;
      item.command       = cmd;
      item.xfer_status   = 2'($urandom_range(3));
      item.byte_count    = 7'($urandom_range(127));
      item.csw_signature = random_word();
      item.csw_status    = 8'($urandom);
      item.capacity_word = random_word();
      return item;
   endfunction

   function automatic req_type completion_item(input logic [1:0] status,
                                                input logic [31:0] capacity);
      req_type item;
      item.func          = FUNC_XFER;
      item.command       = 2'($urandom_range(3));
      item.xfer_status   = status;
      item.byte_count    = 7'($urandom_range(PACKET_BYTES));
      item.csw_signature = random_word();
      item.csw_status    = 8'($urandom);
      item.capacity_word = capacity;
      return item;
   endfunction

   // hold the item until accepted, then maybe idle for a burst
   task automatic send_item(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!quiet_tail && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(6, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one command from cbw to csw; break_at names the completion that fails, if any
   task automatic run_command(input logic [1:0] cmd, input int break_at,
                              input csw_fault_type fault, input logic [31:0] capacity,
                              input int busy_pct);
      int      steps;
      req_type item;
      steps = (cmd == CMD_READ || cmd == CMD_WRITE) ? SECTOR_BYTES / PACKET_BYTES + 2 : 3;
      send_item(cmd_item(cmd));
      sequence_items++;
      for (int i = 0; i < steps; i++) begin
         // a request while busy is ignored
         if ($urandom_range(99) < busy_pct)
            send_item(cmd_item(2'($urandom_range(3))));
         item = completion_item(XST_OK, (i == 1) ? capacity : random_word());
         if (i == break_at) begin
            item.xfer_status = FAULT_STATUS[$urandom_range(2)];
         end else if (i == steps - 1) begin
            item.byte_count    = CSW_LEN;
            item.csw_signature = CSW_SIG;
            item.csw_status    = 8'h00;
            case (fault)
               CSW_BAD_SIZE:   item.byte_count = CSW_LEN ^ 7'($urandom_range(127, 1));
               CSW_BAD_SIG:    item.csw_signature = CSW_SIG ^
                                  (random_word() | (32'h1 << $urandom_range(31)));
               CSW_BAD_STATUS: item.csw_status = 8'($urandom_range(255, 1));
               default:        ;
            endcase
         end
         send_item(item);
         sequence_items++;
         if (i == break_at)
            break;
      end
   endtask

   // stimulus
   initial begin
      csw_fault_type fault;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      cycle_count = 0;
      gap_pct     = 0;
      stall_pct   = 0;
      stall_left  = 0;
      quiet_tail  = 1'b0;
      sequence_items   = 0;
      next_mode_change = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: completion while idle, capacity latch of all ones, full write,
      // request while busy, status three, bad signature and bad csw status
      send_item(completion_item(XST_OK, '1));
      run_command(CMD_CAPACITY, -1, CSW_GOOD, 32'hffff_ffff, 0);
      run_command(CMD_WRITE, -1, CSW_GOOD, '0, 0);
      send_item(cmd_item(CMD_READ));
      send_item(cmd_item(CMD_SENSE));
      send_item(completion_item(XST_OTHER, '0));
      run_command(CMD_CAPACITY, -1, CSW_BAD_SIG, '0, 0);
      run_command(CMD_SENSE, -1, CSW_BAD_STATUS, '1, 0);

      // random: mostly well-formed commands, some noise
      while (sequence_items < ITEM_TARGET) begin
         if (sequence_items >= next_mode_change) begin
            gap_pct   = idle_choice();
            stall_pct = idle_choice();
            next_mode_change = sequence_items + 150;
         end
         quiet_tail = (sequence_items >= ITEM_TARGET - QUIET_ITEMS);
         if ($urandom_range(9) < 8) begin
            fault = ($urandom_range(9) < 6) ? CSW_GOOD : csw_fault_type'($urandom_range(3));
            run_command(2'($urandom_range(3)),
                        ($urandom_range(4) == 0) ? int'($urandom_range(9)) : -1,
                        fault, random_word(), 5);
         end else begin
            repeat ($urandom_range(3, 1)) begin
               req_type item;
               item = cmd_item(2'($urandom_range(3)));
               item.func = 1'($urandom);
               send_item(item);
               sequence_items++;
            end
            // end whatever the noise may have started
            send_item(completion_item(XST_USB_ERR, '0));
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for the pipeline
      @(posedge clock);
      while (awaited_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
